// File: rtl/bdq_pkg.sv
`timescale 1ns / 1ps
package bdq_pkg;

  // Fixed field widths of the stream words.
  localparam int VALUE_W   = 32;
  localparam int REQ_W     = 3;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 40;
  localparam int DEPTH_DEF = 16;

  // Request codes carried in the input tuser.
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_TAIL  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PUSH_HEAD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POP_HEAD  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_LIST      = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  // Strobes from the controller to the entry memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

// File: rtl/bounded_array_deque_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Ports           Contents
// s_axis    in   tdata, tuser    request word: operation code and value to insert
// m_axis    out  tdata, tuser,   result word: success flag, listed entry,
//                tlast           entry flag and end-of-answer mark
//
// Clear, push and drop requests each answer with one word.
// A listing of a non-empty deque holds the request side until its last entry is
// loaded; for each stored entry, ST_READ reads the entry memory, whose read port
// is registered, and ST_SEND then loads the output register.
// Reset clears the count, the head pointer and the output valid; the memory
// itself is not cleared, since only entries below the count are ever read.
// A stalled output holds the request side until the result word is taken.
module bounded_array_deque_unit #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] value
  input  logic [bdq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [2:0] req_type
  input  logic [bdq_pkg::REQ_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] ok, [32:1] item, [39:33] zero
  output logic [bdq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [0] item_valid
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import bdq_pkg::*;

  // Entries live in a ring addressed from a head pointer, so inserting or
  // dropping at the head moves the pointer instead of every stored word.
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ram_ctl_t           ram_ctl;
  logic [IW-1:0]      waddr;
  logic [IW-1:0]      raddr;
  logic [VALUE_W-1:0] wdata;
  logic [VALUE_W-1:0] rdata;
  logic               res_ok;
  logic [VALUE_W-1:0] res_item;

  bdq_ctrl #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .req_type   (s_axis_tuser),
    .value      (s_axis_tdata[VALUE_W-1:0]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .ok         (res_ok),
    .item       (res_item),
    .item_valid (m_axis_tuser),
    .last       (m_axis_tlast),
    .ram_ctl    (ram_ctl),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr      (raddr),
    .rdata      (rdata)
  );

  bdq_ram #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The output word is padded with zeros up to a whole number of bytes.
  assign m_axis_tdata = {(OUT_DATA_W - VALUE_W - 1)'(0), res_item, res_ok};

endmodule

// File: rtl/bdq_ram.sv
`timescale 1ns / 1ps
module bdq_ram #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  bdq_pkg::ram_ctl_t            ctl,
  input  logic [IW-1:0]                waddr,
  input  logic [bdq_pkg::VALUE_W-1:0]  wdata,
  input  logic [IW-1:0]                raddr,
  output logic [bdq_pkg::VALUE_W-1:0]  rdata
);
  import bdq_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bdq_ctrl.sv
`timescale 1ns / 1ps
module bdq_ctrl #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bdq_pkg::REQ_W-1:0]    req_type,
  input  logic [bdq_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         ok,
  output logic [bdq_pkg::VALUE_W-1:0]  item,
  output logic                         item_valid,
  output logic                         last,
  output bdq_pkg::ram_ctl_t            ram_ctl,
  output logic [IW-1:0]                waddr,
  output logic [bdq_pkg::VALUE_W-1:0]  wdata,
  output logic [IW-1:0]                raddr,
  input  logic [bdq_pkg::VALUE_W-1:0]  rdata
);
  import bdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  state_t state, state_next;
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] lidx, lidx_next;
  logic lidx_last, lidx_last_next;

  logic out_valid_next, ok_next, item_valid_next, last_next;
  logic [VALUE_W-1:0] item_next;

  logic slot_free, accept, is_full, is_empty;
  logic [IW-1:0] offset;
  logic [IW:0]   addr_sum;
  logic [IW-1:0] phys;
  logic [IW-1:0] head_dec, head_inc;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign is_full   = (count == DEPTH_C);
  assign is_empty  = (count == '0);

  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;

  // Logical position to ring address: head plus offset, wrapped once.
  assign offset   = (state == ST_IDLE) ? count[IW-1:0] : lidx;
  assign addr_sum = {1'b0, head} + {1'b0, offset};
  assign phys     = (addr_sum >= DEPTH_X) ? IW'(addr_sum - DEPTH_X) : addr_sum[IW-1:0];

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    lidx_next       = lidx;
    lidx_last_next  = lidx_last;
    out_valid_next  = out_valid && !out_ready;
    ok_next         = ok;
    item_next       = item;
    item_valid_next = item_valid;
    last_next       = last;
    ram_ctl         = '0;
    waddr           = phys;
    wdata           = value;
    raddr           = phys;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          out_valid_next  = 1'b1;
          ok_next         = 1'b0;
          item_next       = '0;
          item_valid_next = 1'b0;
          last_next       = 1'b1;
          case (req_type)
            REQ_CLEAR: begin
              count_next = '0;
              ok_next    = 1'b1;
            end
            REQ_PUSH_TAIL: begin
              if (!is_full) begin
                ram_ctl.wr_en = 1'b1;
                count_next    = count + 1'b1;
                ok_next       = 1'b1;
              end
            end
            REQ_POP_TAIL: begin
              if (!is_empty) begin
                count_next = count - 1'b1;
                ok_next    = 1'b1;
              end
            end
            REQ_PUSH_HEAD: begin
              if (!is_full) begin
                ram_ctl.wr_en = 1'b1;
                waddr         = head_dec;
                head_next     = head_dec;
                count_next    = count + 1'b1;
                ok_next       = 1'b1;
              end
            end
            REQ_POP_HEAD: begin
              if (!is_empty) begin
                head_next  = head_inc;
                count_next = count - 1'b1;
                ok_next    = 1'b1;
              end
            end
            REQ_LIST: begin
              if (!is_empty) begin
                out_valid_next = 1'b0;
                lidx_next      = '0;
                state_next     = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        ram_ctl.rd_en  = 1'b1;
        lidx_last_next = ((CW'(lidx) + 1'b1) == count);
        state_next     = ST_SEND;
      end
      ST_SEND: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          ok_next         = 1'b1;
          item_next       = rdata;
          item_valid_next = 1'b1;
          last_next       = lidx_last;
          if (lidx_last) begin
            state_next = ST_IDLE;
          end else begin
            lidx_next  = lidx + 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lidx       <= lidx_next;
    lidx_last  <= lidx_last_next;
    ok         <= ok_next;
    item       <= item_next;
    item_valid <= item_valid_next;
    last       <= last_next;
  end

endmodule

// File: rtl/bdq_checker.sv
`timescale 1ns / 1ps
module bdq_props (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bdq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);
  import bdq_pkg::*;

  // A result word stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // Any word without a listed entry is a single-word answer.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("status word not marked last");

  // Status words carry a zero entry field and zero padding.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[OUT_DATA_W-1:1] == '0))
    else $error("status word carries entry bits");

  // Every listed entry reports success.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[0])
    else $error("listed entry without success flag");

endmodule

bind bounded_array_deque_unit bdq_props u_bdq_props (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
